>>> rtl/sha512mh_pkg.sv
package sha512mh_pkg;

	localparam int QDEPTH_DEF = 4;
	localparam int WORDS_PER_BLOCK = 16;
	localparam int ROUNDS = 80;

	typedef struct packed {
		logic [63:0] word;
		logic        last;
	} blk_word_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] big_s0(input logic [63:0] x);
		return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] big_s1(input logic [63:0] x);
		return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic logic [63:0] small_s0(input logic [63:0] x);
		return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] small_s1(input logic [63:0] x);
		return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] iv_word(input logic [2:0] i);
		logic [63:0] r;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			default: r = 64'h5be0cd19137e2179;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] round_key(input logic [6:0] t);
		logic [63:0] k;
		case (t)
			7'd0: k = 64'h428a2f98d728ae22;
			7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f;
			7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538;
			7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b;
			7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242;
			7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c;
			7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f;
			7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235;
			7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2;
			7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5;
			7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275;
			7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4;
			7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab;
			7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f;
			7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2;
			7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f;
			7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc;
			7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed;
			7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de;
			7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6;
			7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364;
			7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791;
			7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218;
			7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a;
			7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8;
			7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99;
			7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63;
			7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373;
			7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc;
			7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72;
			7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28;
			7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915;
			7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c;
			7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e;
			7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba;
			7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae;
			7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84;
			7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc;
			7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6;
			7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec;
			7'd79: k = 64'h6c44198c4a475817;
			default: k = 64'h0;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/sha512mh_front.sv
module sha512mh_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [63:0]            message_word,
	input  logic [3:0]             valid_bytes,
	input  logic                   final_word,
	output logic                   q_valid,
	input  logic                   q_ready,
	output sha512mh_pkg::blk_word_t q_data
);
	import sha512mh_pkg::*;

	typedef enum logic [1:0] {
		F_IN  = 2'b01,
		F_PAD = 2'b10
	} fstate_t;

	fstate_t     state_q;
	logic [3:0]  slot_q;
	logic [63:0] total_q;
	logic        need80_q;
	logic        zero_q;

	logic [3:0]  nb;
	logic [3:0]  nb_eff;
	logic [63:0] padded;
	logic        push;
	logic        accept;
	logic        len_now;

	assign nb     = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
	assign nb_eff = final_word ? nb : 4'd8;

	// keep the leading nb bytes, 0x80 right after them, zeros below
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < nb) begin
				padded[63 - 8*i -: 8] = message_word[63 - 8*i -: 8];
			end else if (4'(i) == nb) begin
				padded[63 - 8*i -: 8] = 8'h80;
			end else begin
				padded[63 - 8*i -: 8] = 8'h00;
			end
		end
	end

	// length goes in the last slot only if the slot before it is pad zero
	assign len_now = (slot_q == 4'd15) && zero_q && !need80_q;

	always_comb begin
		q_data.word = 64'h0;
		q_data.last = 1'b0;
		q_valid     = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			F_IN: begin
				in_ready    = q_ready;
				q_valid     = in_valid;
				q_data.word = (final_word && nb != 4'd8) ? padded : message_word;
			end
			F_PAD: begin
				q_valid = 1'b1;
				if (need80_q) begin
					q_data.word = 64'h8000000000000000;
				end else if (len_now) begin
					q_data.word = {total_q[60:0], 3'b000};
					q_data.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign push   = q_valid && q_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IN;
			slot_q   <= 4'd0;
			total_q  <= 64'd0;
			need80_q <= 1'b0;
			zero_q   <= 1'b0;
		end else begin
			if (push) begin
				slot_q <= slot_q + 4'd1;
			end
			case (state_q)
				F_IN: begin
					if (accept) begin
						total_q <= total_q + {60'd0, nb_eff};
						if (final_word) begin
							state_q  <= F_PAD;
							need80_q <= (nb == 4'd8);
							zero_q   <= 1'b0;
						end
					end
				end
				F_PAD: begin
					if (push) begin
						if (need80_q) begin
							need80_q <= 1'b0;
						end else if (len_now) begin
							state_q <= F_IN;
							total_q <= 64'd0;
							zero_q  <= 1'b0;
						end else begin
							zero_q <= 1'b1;
						end
					end
				end
				default: state_q <= F_IN;
			endcase
		end
	end

endmodule

>>> rtl/sha512mh_queue.sv
module sha512mh_queue #(
	parameter int DEPTH = sha512mh_pkg::QDEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  sha512mh_pkg::blk_word_t push_data,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output sha512mh_pkg::blk_word_t pop_data
);
	import sha512mh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	blk_word_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/sha512mh_back.sv
module sha512mh_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  sha512mh_pkg::blk_word_t pop_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [63:0]             digest_word,
	output logic [2:0]              digest_index,
	output logic                    digest_done
);
	import sha512mh_pkg::*;

	typedef enum logic [3:0] {
		B_LOAD  = 4'b0001,
		B_ROUND = 4'b0010,
		B_ADD   = 4'b0100,
		B_OUT   = 4'b1000
	} bstate_t;

	bstate_t     state_q;
	logic [63:0] h_q [8];
	logic [63:0] v_q [8];
	logic [63:0] w_q [16];
	logic [6:0]  cnt_q;
	logic [2:0]  idx_q;
	logic        last_q;

	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] w_next;
	logic        take;

	assign t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
	          + round_key(cnt_q) + w_q[0];
	assign t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	// w_q[k] holds W[t+k]; the new word is W[t+16]
	assign w_next = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];

	assign pop_ready    = (state_q == B_LOAD);
	assign take         = pop_valid && pop_ready;
	assign out_valid    = (state_q == B_OUT);
	assign digest_word  = h_q[idx_q];
	assign digest_index = idx_q;
	assign digest_done  = (idx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (take || state_q == B_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= take ? pop_data.word : w_next;
		end
		if (take && cnt_q == 7'd15) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == B_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			cnt_q   <= 7'd0;
			idx_q   <= 3'd0;
			last_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= iv_word(3'(i));
			end
		end else begin
			case (state_q)
				B_LOAD: begin
					if (take) begin
						if (cnt_q == 7'd15) begin
							cnt_q   <= 7'd0;
							last_q  <= pop_data.last;
							state_q <= B_ROUND;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				B_ROUND: begin
					if (cnt_q == 7'(ROUNDS - 1)) begin
						cnt_q   <= 7'd0;
						state_q <= B_ADD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					idx_q   <= 3'd0;
					state_q <= last_q ? B_OUT : B_LOAD;
				end
				B_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= iv_word(3'(i));
							end
							state_q <= B_LOAD;
						end
					end
				end
				default: state_q <= B_LOAD;
			endcase
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ROUND |-> cnt_q < 7'(ROUNDS))
		else $error("round counter out of range");

	a_load_to_round: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cnt_q == 7'd15) |=> (state_q == B_ROUND && cnt_q == 7'd0))
		else $error("full block did not start compression");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(idx_q)))
		else $error("digest word dropped while stalled");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ROUND || state_q == B_OUT) |-> !pop_ready)
		else $error("queue popped while busy");

endmodule

>>> rtl/sha512_message_hasher_top.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | message_word, valid_bytes, final_word
// out     | output    | out_valid / out_ready | digest_word, digest_index, digest_done
//
// Each 128-byte block: the 16-word window is loaded from the queue, 80 rounds
// run, then the working variables are folded into the chaining hash.
// Rate is set by the single-round compression datapath.
// Padding words come from the front while the back compresses; the queue absorbs them.
// Digest: 8 transfers after the final block; out_ready low holds the current word.
// arst_n clears all control state; the chaining hash resets to the initial values.
module sha512_message_hasher_top #(
	parameter int QDEPTH = sha512mh_pkg::QDEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        final_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_done
);
	import sha512mh_pkg::*;

	blk_word_t push_data;
	blk_word_t pop_data;
	logic      push_valid;
	logic      push_ready;
	logic      pop_valid;
	logic      pop_ready;

	sha512mh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.message_word (message_word),
		.valid_bytes  (valid_bytes),
		.final_word   (final_word),
		.q_valid      (push_valid),
		.q_ready      (push_ready),
		.q_data       (push_data)
	);

	sha512mh_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sha512mh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_done  (digest_done)
	);

endmodule
